/* rtl/swrl_pkg.sv */
package swrl_pkg;

	localparam int DEF_CLIENTS = 16;
	localparam int DEF_SLOTS   = 16;

	// APB register map: byte address 4*i, index taken from paddr[2]
	localparam int ADDR_W = 3;
	localparam logic REG_MAX_REQ = 1'b0;
	localparam logic REG_WINDOW  = 1'b1;

	localparam logic [4:0]  MAX_REQ_RST = 5'd10;
	localparam logic [30:0] WINDOW_RST  = 31'd1000;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_META,
		ST_TEST,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

/* rtl/sliding_window_rate_limiter.sv */
// A check request reads its client entry, then drops its k stale stamps, one per cycle
// through the stamp memory (k in 0..SLOTS), then writes back and presents its result,
// which the output stall can hold. No new request is accepted until that result is in
// the output register; a clear request sweeps the client table one entry a cycle.
// Reset (arst_n low, asynchronous): control and configuration registers take their
// reset values, then a sweep empties every client; no request is accepted during the sweep.
module sliding_window_rate_limiter #(
	parameter int CLIENTS = swrl_pkg::DEF_CLIENTS,
	parameter int SLOTS   = swrl_pkg::DEF_SLOTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swrl_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// request channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [3:0]                  client_index,
	input  logic [47:0]                 now_ms,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        allowed,
	output logic [4:0]                  in_window_count
);

	import swrl_pkg::*;

	localparam int CLW   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int MW    = SW + CW;
	localparam int DEPTH = CLIENTS * SLOTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// configuration registers
	logic [4:0]  max_req_q;
	logic [30:0] window_q;

	// control
	state_t state_q, state_d;
	logic [CLW-1:0] clr_idx_q;
	logic           clr_res_q;

	// request in flight
	logic [CLW-1:0] cl_q;
	logic [AW-1:0]  base_q;
	logic [47:0]    now_q;
	logic [47:0]    start_q;
	logic           drop_en_q;
	logic [SW-1:0]  oldest_q;
	logic [CW-1:0]  count_q;
	logic           res_allowed_q;
	logic [4:0]     res_count_q;

	// output register
	logic       out_valid_q;
	logic       out_allowed_q;
	logic [4:0] out_count_q;

	// memory ports
	logic          meta_we;
	logic [CLW-1:0] meta_waddr;
	logic [MW-1:0] meta_wdata;
	logic [MW-1:0] meta_rdata;
	logic          stamp_we;
	logic [AW-1:0] stamp_waddr;
	logic [AW-1:0] stamp_raddr;
	logic [47:0]   stamp_rdata;

	// request decode
	logic [31:0]    cl_ext;
	logic [CLW-1:0] cl_idx;
	logic           client_ok;
	logic           acc;
	logic           load_out;

	// step datapath
	logic [SW-1:0] meta_oldest;
	logic [CW-1:0] meta_count;
	logic [SW-1:0] oldest_inc;
	logic          stale;
	logic          room;
	logic [31:0]   tail_sum;
	logic [SW-1:0] tail;
	logic [CW-1:0] new_count;
	logic [31:0]   new_count_ext;
	logic          clr_last;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WINDOW) ? {1'b0, window_q} : {27'b0, max_req_q};

	assign in_stall        = (state_q != ST_IDLE);
	assign acc             = in_valid && !in_stall;
	assign out_valid       = out_valid_q;
	assign allowed         = out_allowed_q;
	assign in_window_count = out_count_q;

	assign cl_ext    = 32'(client_index);
	assign cl_idx    = cl_ext[CLW-1:0];
	assign client_ok = (cl_ext < 32'(CLIENTS));

	assign meta_oldest = meta_rdata[MW-1:CW];
	assign meta_count  = meta_rdata[CW-1:0];
	assign oldest_inc  = (32'(oldest_q) + 32'd1 == 32'(SLOTS)) ? '0 : oldest_q + SW'(1);

	// oldest stamp strictly before the window start, only when the window starts at or after zero
	assign stale = drop_en_q && (count_q != '0) && (stamp_rdata < start_q);

	// ring saturates at SLOTS; max_requests bounds the admitted count
	assign room     = (32'(count_q) < 32'(max_req_q)) && (32'(count_q) < 32'(SLOTS));
	assign tail_sum = 32'(oldest_q) + 32'(count_q);
	assign tail     = (tail_sum >= 32'(SLOTS)) ? SW'(tail_sum - 32'(SLOTS)) : SW'(tail_sum);
	assign new_count     = room ? count_q + CW'(1) : count_q;
	assign new_count_ext = 32'(new_count);

	assign clr_last = (32'(clr_idx_q) == 32'(CLIENTS - 1));
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	swrl_ram #(
		.Width (MW),
		.Depth (CLIENTS)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (cl_idx),
		.rdata (meta_rdata)
	);

	swrl_ram #(
		.Width (48),
		.Depth (DEPTH)
	) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (stamp_waddr),
		.wdata (now_q),
		.raddr (stamp_raddr),
		.rdata (stamp_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = clr_res_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					if (mode) begin
						state_d = ST_CLEAR;
					end else if (!client_ok) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_META;
					end
				end
			end
			ST_META:  state_d = ST_TEST;
			ST_TEST: begin
				if (!stale) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_DONE;
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		meta_we     = 1'b0;
		meta_waddr  = cl_q;
		meta_wdata  = {oldest_q, new_count};
		stamp_we    = 1'b0;
		stamp_waddr = base_q + AW'(tail);
		stamp_raddr = base_q + AW'(oldest_inc);
		case (state_q)
			ST_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_idx_q;
				meta_wdata = '0;
			end
			ST_META: begin
				// fetch the oldest stamp as the client entry arrives
				stamp_raddr = base_q + AW'(meta_oldest);
			end
			ST_WRITE: begin
				meta_we  = 1'b1;
				stamp_we = room;
			end
			default: begin
				meta_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			clr_res_q   <= 1'b0;
			out_valid_q <= 1'b0;
			max_req_q   <= MAX_REQ_RST;
			window_q    <= WINDOW_RST;
		end else begin
			state_q <= state_d;

			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_WINDOW) begin
					window_q <= pwdata[30:0];
				end else begin
					max_req_q <= pwdata[4:0];
				end
			end

			// advance the sweep; rewind it when a clear request arrives
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_last ? '0 : clr_idx_q + CLW'(1);
			end
			if (acc) begin
				clr_idx_q <= '0;
				clr_res_q <= mode;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (acc) begin
			cl_q          <= cl_idx;
			base_q        <= AW'(cl_ext * 32'(SLOTS));
			now_q         <= now_ms;
			drop_en_q     <= (now_ms >= {17'b0, window_q});
			start_q       <= now_ms - {17'b0, window_q};
			res_allowed_q <= 1'b0;
			res_count_q   <= '0;
		end
		case (state_q)
			ST_META: begin
				oldest_q <= meta_oldest;
				count_q  <= meta_count;
			end
			ST_TEST: begin
				// drop the oldest stamp and look at the next one
				if (stale) begin
					oldest_q <= oldest_inc;
					count_q  <= count_q - CW'(1);
				end
			end
			ST_WRITE: begin
				res_allowed_q <= room;
				res_count_q   <= new_count_ext[4:0];
			end
			default: ;
		endcase
		if (load_out) begin
			out_allowed_q <= res_allowed_q;
			out_count_q   <= res_count_q;
		end
	end

`ifndef SYNTH
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> (32'(count_q) <= 32'(SLOTS)))
		else $error("client stamp count above ring size");

	a_allow_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_allowed_q) |-> (out_count_q != 5'd0))
		else $error("admitted request with empty count");

	a_stamp_write: assert property (@(posedge clk) disable iff (!arst_n)
		stamp_we |-> (state_q == ST_WRITE) && (32'(count_q) < 32'(max_req_q)))
		else $error("stamp written without room");
`endif

endmodule

/* rtl/swrl_ram.sv */
module swrl_ram #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr,
	input  logic [Width-1:0]                         wdata,
	input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr,
	output logic [Width-1:0]                         rdata
);

	logic [Width-1:0] mem [Depth];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
